/* src/bmp_pixel_to_rgb222_macros.svh */
// ---------------------------------------------------------------------------
// bmp_pixel_to_rgb222 assertion macros
// Concurrent assertion shorthands on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef BMP_PIXEL_TO_RGB222_MACROS_SVH
`define BMP_PIXEL_TO_RGB222_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons must hold (may be a sequence).
`define BMP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bmp_pixel_to_rgb222: assertion failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define BMP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bmp_pixel_to_rgb222: assertion failed");

`else

`define BMP_ASSERT_IMPL(label, ante, cons)
`define BMP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* src/bmp_rgb222_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmp_rgb222_pkg
// Shared types, register map and helper functions of the RGB222 converter.
// ---------------------------------------------------------------------------
package bmp_rgb222_pkg;

  localparam int unsigned NumChan = 3;
  localparam int unsigned ChanRed = 0;
  localparam int unsigned ChanGreen = 1;
  localparam int unsigned ChanBlue = 2;

  // Register indexes (byte address bits 3:2).
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_RED   = 2'd1;
  localparam logic [1:0] REG_GREEN = 2'd2;
  localparam logic [1:0] REG_BLUE  = 2'd3;

  localparam logic [31:0] RED_MASK_RESET   = 32'h00FF_0000;
  localparam logic [31:0] GREEN_MASK_RESET = 32'h0000_FF00;
  localparam logic [31:0] BLUE_MASK_RESET  = 32'h0000_00FF;

  // Quantizer thresholds: (c*3 + 127) / 255 steps up at these values of c.
  localparam logic [7:0] QUANT_T1 = 8'd43;
  localparam logic [7:0] QUANT_T2 = 8'd128;
  localparam logic [7:0] QUANT_T3 = 8'd213;

  // Per-channel setup, derived once when a mask is written.
  typedef struct packed {
    logic [31:0] mask;
    logic [5:0]  width;   // number of set mask bits, 0 to 32
    logic [4:0]  shift;   // trailing zeros of the mask
    logic [31:0] maxv;    // 2^width - 1
    logic [31:0] recip;   // floor(2^32 / maxv), used for width of 2 or more
  } chan_cfg_t;

  function automatic logic [5:0] ones_count(logic [31:0] m);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      n = n + {5'd0, m[i]};
    end
    return n;
  endfunction

  function automatic logic [4:0] trailing_zeros(logic [31:0] m);
    logic [4:0] n;
    n = '0;
    for (int i = 31; i >= 0; i--) begin
      if (m[i]) begin
        n = 5'(i);
      end
    end
    return n;
  endfunction

  // 2^32 / (2^w - 1) is the series 2^(32-w) + 2^(32-2w) + ...; for w of two
  // or more the fractional tail stays below one, so the floor is the sum of
  // the integer terms: a repeating bit pattern.
  function automatic logic [31:0] recip_of(logic [5:0] w);
    logic [31:0] r;
    r = '0;
    for (int k = 1; k <= 32; k++) begin
      if (w != 6'd0 && k * int'(w) <= 32) begin
        r[32 - k * int'(w)] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic chan_cfg_t make_cfg(logic [31:0] m);
    chan_cfg_t c;
    logic [32:0] mx;
    c.mask  = m;
    c.width = ones_count(m);
    c.shift = trailing_zeros(m);
    mx      = (33'd1 << c.width) - 33'd1;
    c.maxv  = mx[31:0];
    c.recip = recip_of(c.width);
    return c;
  endfunction

  function automatic logic [1:0] quant2(logic [7:0] c);
    logic [1:0] q;
    q = 2'd0;
    if (c >= QUANT_T1) q = 2'd1;
    if (c >= QUANT_T2) q = 2'd2;
    if (c >= QUANT_T3) q = 2'd3;
    return q;
  endfunction

  localparam chan_cfg_t RED_CFG_RESET   = make_cfg(RED_MASK_RESET);
  localparam chan_cfg_t GREEN_CFG_RESET = make_cfg(GREEN_MASK_RESET);
  localparam chan_cfg_t BLUE_CFG_RESET  = make_cfg(BLUE_MASK_RESET);

endpackage

/* src/bmp_pixel_to_rgb222.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmp_pixel_to_rgb222
// Converts one bitmap pixel word per clock into a packed RGB222 color.
// ---------------------------------------------------------------------------
//
// Channel   | Handshake                            | Payload
// ----------+--------------------------------------+-------------------------
// pixel in  | start_i, taken when busy_o is low    | pixel_word_i [31:0]
// color out | done_o, one-cycle strobe, no stall   | rgb222_o [5:0]
// config    | APB write on psel/penable/pwrite     | paddr [3:0], pwdata [31:0]
//
// A word enters on every clock: busy_o never rises. Each word's color is on
// rgb222_o, with done_o high, once the word has passed the six pipeline
// registers (mask and shift, scale numerator, reciprocal product, quotient
// estimate, remainder correction, quantize and pack). Reset clears the valid
// bits and restores the register defaults. The receiver cannot stall, so
// nothing in the pipeline ever waits.
//
// In bitfield mode each channel is divided by 2^w - 1 through a fixed-point
// reciprocal taken when the mask is written, followed by a single
// remainder check that adds one where the estimate fell short.
`include "bmp_pixel_to_rgb222_macros.svh"

module bmp_pixel_to_rgb222 (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Pixel input.
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] pixel_word_i,
  // Color output.
  output logic        done_o,
  output logic [5:0]  rgb222_o,
  // Configuration.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned NC = bmp_rgb222_pkg::NumChan;

  // -------------------------------------------------------------------------
  // Configuration registers.
  // -------------------------------------------------------------------------
  logic                      mode_q, mode_d;
  bmp_rgb222_pkg::chan_cfg_t chan_q [NC];
  bmp_rgb222_pkg::chan_cfg_t chan_d [NC];
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    mode_d = mode_q;
    for (int c = 0; c < NC; c++) begin
      chan_d[c] = chan_q[c];
    end
    if (cfg_wr) begin
      case (paddr[3:2])
        bmp_rgb222_pkg::REG_MODE: begin
          mode_d = pwdata[0];
        end
        bmp_rgb222_pkg::REG_RED: begin
          chan_d[bmp_rgb222_pkg::ChanRed] = bmp_rgb222_pkg::make_cfg(pwdata);
        end
        bmp_rgb222_pkg::REG_GREEN: begin
          chan_d[bmp_rgb222_pkg::ChanGreen] = bmp_rgb222_pkg::make_cfg(pwdata);
        end
        bmp_rgb222_pkg::REG_BLUE: begin
          chan_d[bmp_rgb222_pkg::ChanBlue] = bmp_rgb222_pkg::make_cfg(pwdata);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      chan_q[bmp_rgb222_pkg::ChanRed]   <= bmp_rgb222_pkg::RED_CFG_RESET;
      chan_q[bmp_rgb222_pkg::ChanGreen] <= bmp_rgb222_pkg::GREEN_CFG_RESET;
      chan_q[bmp_rgb222_pkg::ChanBlue]  <= bmp_rgb222_pkg::BLUE_CFG_RESET;
    end else begin
      mode_q <= mode_d;
      for (int c = 0; c < NC; c++) begin
        chan_q[c] <= chan_d[c];
      end
    end
  end

  always_comb begin
    case (paddr[3:2])
      bmp_rgb222_pkg::REG_MODE:  prdata = {31'd0, mode_q};
      bmp_rgb222_pkg::REG_RED:   prdata = chan_q[bmp_rgb222_pkg::ChanRed].mask;
      bmp_rgb222_pkg::REG_GREEN: prdata = chan_q[bmp_rgb222_pkg::ChanGreen].mask;
      bmp_rgb222_pkg::REG_BLUE:  prdata = chan_q[bmp_rgb222_pkg::ChanBlue].mask;
      default:                   prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Pipeline valid bits.
  // -------------------------------------------------------------------------
  logic accept;
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, s6_vld_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
    end
  end

  // -------------------------------------------------------------------------
  // Datapath. In plain mode the channel byte rides in the numerator slot
  // and is taken unchanged at the correction stage.
  // -------------------------------------------------------------------------
  logic [31:0] s1_v_q   [NC];
  logic [31:0] s2_num_q [NC];
  logic [31:0] s3_num_q [NC];
  logic [63:0] s3_prod_q[NC];
  logic [31:0] s4_num_q [NC];
  logic [31:0] s4_q0_q  [NC];
  logic [7:0]  s5_c_q   [NC];
  logic [5:0]  s6_rgb_q;

  logic [31:0] v_d    [NC];
  logic [31:0] num_d  [NC];
  logic [31:0] q0_d   [NC];
  logic [7:0]  c_d    [NC];
  logic [33:0] qd     [NC];
  logic [33:0] rem    [NC];
  logic [33:0] dd     [NC];
  logic        carry  [NC];
  logic        rem_ok;
  logic [5:0]  rgb_d;

  always_comb begin
    rem_ok = 1'b1;
    for (int c = 0; c < NC; c++) begin
      // Stage 1: select and align the field.
      if (mode_q) begin
        v_d[c] = (pixel_word_i & chan_q[c].mask) >> chan_q[c].shift;
      end else begin
        v_d[c] = {24'd0, pixel_word_i[8*(NC-1-c) +: 8]};
      end
      // Stage 2: v*255 + maxv/2 in bitfield mode, wrapping at 32 bits.
      if (mode_q) begin
        num_d[c] = (s1_v_q[c] << 8) - s1_v_q[c] + (chan_q[c].maxv >> 1);
      end else begin
        num_d[c] = s1_v_q[c];
      end
      // Stage 4: quotient estimate, exact for a one-bit mask.
      if (chan_q[c].width == 6'd1) begin
        q0_d[c] = s3_num_q[c];
      end else begin
        q0_d[c] = s3_prod_q[c][63:32];
      end
      // Stage 5: the estimate is at most one short; check the remainder.
      qd[c]    = ({2'd0, s4_q0_q[c]} << chan_q[c].width) - {2'd0, s4_q0_q[c]};
      rem[c]   = {2'd0, s4_num_q[c]} - qd[c];
      dd[c]    = {2'd0, chan_q[c].maxv};
      carry[c] = (rem[c] >= dd[c]);
      if (!mode_q) begin
        c_d[c] = s4_num_q[c][7:0];
      end else if (chan_q[c].width == 6'd0) begin
        c_d[c] = 8'd0;
      end else begin
        c_d[c] = s4_q0_q[c][7:0] + {7'd0, carry[c]};
      end
      if (mode_q && chan_q[c].width != 6'd0 && carry[c] && (rem[c] - dd[c]) >= dd[c]) begin
        rem_ok = 1'b0;
      end
    end
    // Stage 6: quantize and pack.
    rgb_d = {bmp_rgb222_pkg::quant2(s5_c_q[bmp_rgb222_pkg::ChanRed]),
             bmp_rgb222_pkg::quant2(s5_c_q[bmp_rgb222_pkg::ChanGreen]),
             bmp_rgb222_pkg::quant2(s5_c_q[bmp_rgb222_pkg::ChanBlue])};
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NC; c++) begin
      s1_v_q[c]    <= v_d[c];
      s2_num_q[c]  <= num_d[c];
      s3_num_q[c]  <= s2_num_q[c];
      s3_prod_q[c] <= {32'd0, s2_num_q[c]} * {32'd0, chan_q[c].recip};
      s4_num_q[c]  <= s3_num_q[c];
      s4_q0_q[c]   <= q0_d[c];
      s5_c_q[c]    <= c_d[c];
    end
    s6_rgb_q <= rgb_d;
  end

  assign done_o   = s6_vld_q;
  assign rgb222_o = s6_rgb_q;

  // -------------------------------------------------------------------------
  // Assertions.
  // -------------------------------------------------------------------------
  `BMP_ASSERT_IMPL(a_word_latency, accept, ##6 done_o)
  `BMP_ASSERT_IMPL(a_done_has_source, done_o, $past(accept, 6))
  `BMP_ASSERT_IMPL(a_single_correction, s4_vld_q, rem_ok)
  `BMP_ASSERT_NEXT(a_stage5_feeds_out, s5_vld_q, done_o)

endmodule
